// ===== rtl/afoc_pkg.sv =====
// Shared constants for the aspect fit or fill crop block.
// Used by the top level; depends on nothing else.
package afoc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PANEL_WIDTH  = 2'd0,
    REG_PANEL_HEIGHT = 2'd1,
    REG_FILL_MODE    = 2'd2,
    REG_PAN_PERCENT  = 2'd3
  } reg_idx_e;

  // Pan register width and the divisor that turns half-percent steps into a fraction.
  localparam int unsigned PanBits = 8;
  localparam int unsigned PanDiv  = 200;

  // The pan division drops three bits (200 = 8 * 25) and then multiplies by a
  // rounded-up reciprocal of 25 scaled by 2**PanShift; the rounding error is
  // small enough that the quotient is exact for every pan product.
  localparam int unsigned PanShift = 26;
  localparam int unsigned PanRecip = ((1 << PanShift) + PanDiv / 8 - 1) / (PanDiv / 8);

endpackage

// ===== rtl/afoc_cell.sv =====
// One restoring division cell: produces one quotient bit per cycle while en_i is high.
// Standalone; instantiated by afoc_div_chain.
module afoc_cell #(
  parameter int unsigned DW = 12,
  parameter int unsigned NW = 24,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [DW-1:0] div_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic          valid_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] nq_q, nq_d;
  logic [DW-1:0] div_q;
  logic [SW-1:0] side_q;

  // Bring down the next numerator bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_i, nq_i[NW-1]};
    diff  = trial - {1'b0, div_i};
    ge    = (trial >= {1'b0, div_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_d  = {nq_i[NW-2:0], ge};
  end

  // Valid flag is control state; the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/afoc_div_chain.sv =====
// Pipelined divider built as a row of afoc_cell instances.
// Depends on afoc_cell.
module afoc_div_chain #(
  parameter int unsigned DW = 12,
  parameter int unsigned NW = 24,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          valid_w [NW+1];
  logic [DW-1:0] rem_w   [NW+1];
  logic [NW-1:0] nq_w    [NW+1];
  logic [DW-1:0] div_w   [NW+1];
  logic [SW-1:0] side_w  [NW+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = '0;
  assign nq_w[0]    = num_i;
  assign div_w[0]   = div_i;
  assign side_w[0]  = side_i;

  // Each cell hands remainder, shifting numerator/quotient and sideband to the next.
  for (genvar g = 0; g < NW; g++) begin : g_cell
    afoc_cell #(.DW(DW), .NW(NW), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_w[g]),
      .rem_i   (rem_w[g]),
      .nq_i    (nq_w[g]),
      .div_i   (div_w[g]),
      .side_i  (side_w[g]),
      .valid_o (valid_w[g+1]),
      .rem_o   (rem_w[g+1]),
      .nq_o    (nq_w[g+1]),
      .div_o   (div_w[g+1]),
      .side_o  (side_w[g+1])
    );
  end

  assign valid_o = valid_w[NW];
  assign quot_o  = nq_w[NW];
  assign side_o  = side_w[NW];

endmodule

// ===== rtl/aspect_fit_or_fill_crop.sv =====
// Top level of the aspect fit or fill crop block.
// Depends on afoc_pkg and afoc_div_chain.
//
// Each transaction carries a source picture size and yields one result with the
// source crop and the panel rectangle, either letterboxed or cropped to fill.
// The block is a single pipeline that takes one transaction every cycle; it
// runs through the product register, the two parallel aspect dividers and
// the select, pan product, pan reciprocal and output registers. The whole
// pipeline stalls only when a result waits at the output and the sink is
// not ready.
module aspect_fit_or_fill_crop #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [DIM_BITS-1:0]           cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [DIM_BITS-1:0]           source_width_i,
  input  logic [DIM_BITS-1:0]           source_height_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [DIM_BITS-1:0]           crop_left_o,
  output logic [DIM_BITS-1:0]           crop_top_o,
  output logic [DIM_BITS-1:0]           crop_width_o,
  output logic [DIM_BITS-1:0]           crop_height_o,
  output logic [DIM_BITS-1:0]           dest_left_o,
  output logic [DIM_BITS-1:0]           dest_top_o,
  output logic [DIM_BITS-1:0]           dest_width_o,
  output logic [DIM_BITS-1:0]           dest_height_o,
  output logic                          bad_size_o
);

  localparam int unsigned D   = DIM_BITS;
  localparam int unsigned QW  = 2 * D;
  localparam int unsigned PB  = afoc_pkg::PanBits;
  localparam int unsigned MW  = D + PB;
  localparam int unsigned SW3 = 9 * D + 4;
  localparam int unsigned YW  = MW - 3;
  localparam int unsigned RW  = $clog2(afoc_pkg::PanRecip + 1);
  localparam int unsigned PW  = YW + RW;

  // Configuration registers.
  logic [D-1:0]  pw_q, ph_q;
  logic          fill_q;
  logic [PB-1:0] pan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q   <= D'(640);
      ph_q   <= D'(480);
      fill_q <= 1'b0;
      pan_q  <= '0;
    end else if (cfg_we_i) begin
      case (afoc_pkg::reg_idx_e'(cfg_idx_i))
        afoc_pkg::REG_PANEL_WIDTH:  pw_q   <= cfg_data_i;
        afoc_pkg::REG_PANEL_HEIGHT: ph_q   <= cfg_data_i;
        afoc_pkg::REG_FILL_MODE:    fill_q <= cfg_data_i[0];
        afoc_pkg::REG_PAN_PERCENT:  pan_q  <= cfg_data_i[PB-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless a result is held at the output.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: cross products and divisor selection.
  logic          v0_q, fsel_d, fsel0_q;
  logic [QW-1:0] pa0_q, pb0_q;
  logic [D-1:0]  d1_0_q, d2_0_q, sw0_q, sh0_q;

  assign fsel_d = fill_q && (source_width_i != '0) && (source_height_i != '0)
                  && (ph_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa0_q   <= QW'(source_height_i) * QW'(pw_q);
      pb0_q   <= QW'(source_width_i) * QW'(ph_q);
      d1_0_q  <= fsel_d ? ph_q : source_width_i;
      d2_0_q  <= fsel_d ? pw_q : source_height_i;
      sw0_q   <= source_width_i;
      sh0_q   <= source_height_i;
      fsel0_q <= fsel_d;
    end
  end

  // Two dividers side by side: the first and the fallback quotient of either mode.
  logic          va, vb;
  logic [QW-1:0] qa, qb;
  logic [QW-1:0] side_a;
  logic          fsel_b;

  afoc_div_chain #(.DW(D), .NW(QW), .SW(QW)) u_div_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v0_q),
    .num_i(pa0_q), .div_i(d1_0_q), .side_i({sw0_q, sh0_q}),
    .valid_o(va), .quot_o(qa), .side_o(side_a)
  );

  afoc_div_chain #(.DW(D), .NW(QW), .SW(1)) u_div_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v0_q),
    .num_i(pb0_q), .div_i(d2_0_q), .side_i(fsel0_q),
    .valid_o(vb), .quot_o(qb), .side_o(fsel_b)
  );

  // Stage 1: choose the axis or the fit, and place the panel rectangle.
  logic [D-1:0] swa, sha;
  logic         axis_d, bad_d;
  logic [D-1:0] csz_d, left_d, dl_d, dt_d, dw_d, dh_d, fw, fh;

  assign swa = side_a[QW-1:D];
  assign sha = side_a[D-1:0];

  always_comb begin
    axis_d = 1'b0;
    bad_d  = 1'b0;
    csz_d  = '0;
    left_d = '0;
    fw     = pw_q;
    fh     = qa[D-1:0];
    dl_d   = '0;
    dt_d   = '0;
    dw_d   = pw_q;
    dh_d   = ph_q;
    if (fsel_b) begin
      if (qa <= QW'(swa)) begin
        csz_d  = {qa[D-1:1], 1'b0};
        left_d = swa - csz_d;
      end else begin
        axis_d = 1'b1;
        csz_d  = {qb[D-1:1], 1'b0};
        left_d = sha - csz_d;
      end
    end else if (swa == '0 || sha == '0) begin
      bad_d = 1'b1;
      dw_d  = '0;
      dh_d  = '0;
      dl_d  = pw_q >> 1;
      dt_d  = ph_q >> 1;
    end else begin
      if (qa > QW'(ph_q)) begin
        fw = qb[D-1:0];
        fh = ph_q;
      end
      dw_d = {fw[D-1:1], 1'b0};
      dh_d = {fh[D-1:1], 1'b0};
      dl_d = (pw_q - dw_d) >> 1;
      dt_d = (ph_q - dh_d) >> 1;
    end
  end

  logic         v1_q, fsel1_q, axis1_q, bad1_q;
  logic [D-1:0] sw1_q, sh1_q, csz1_q, left1_q, dl1_q, dt1_q, dw1_q, dh1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= va && vb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fsel1_q <= fsel_b;
      axis1_q <= axis_d;
      bad1_q  <= bad_d;
      sw1_q   <= swa;
      sh1_q   <= sha;
      csz1_q  <= csz_d;
      left1_q <= left_d;
      dl1_q   <= dl_d;
      dt1_q   <= dt_d;
      dw1_q   <= dw_d;
      dh1_q   <= dh_d;
    end
  end

  // Stage 2: pan product as sign and magnitude.
  logic [PB-1:0] pan_mag;
  logic          v2_q;
  logic [MW-1:0] mag2_q;
  logic [SW3-1:0] side2_q;

  assign pan_mag = pan_q[PB-1] ? (~pan_q + PB'(1)) : pan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag2_q  <= MW'(left1_q) * MW'(pan_mag);
      side2_q <= {fsel1_q, axis1_q, bad1_q, pan_q[PB-1], sw1_q, sh1_q, csz1_q,
                  left1_q, {1'b0, left1_q[D-1:2], 1'b0}, dl1_q, dt1_q, dw1_q, dh1_q};
    end
  end

  // Stage 3: divide the pan magnitude by the constant 200, truncating. The
  // low three bits are dropped and the rest is multiplied by the reciprocal of 25.
  logic [PW-1:0]  recip_prod;
  logic           v3_q;
  logic [D-1:0]   q3_q;
  logic [SW3-1:0] side3_q;

  assign recip_prod = PW'(mag2_q[MW-1:3]) * PW'(afoc_pkg::PanRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q3_q    <= recip_prod[afoc_pkg::PanShift +: D];
      side3_q <= side2_q;
    end
  end

  // Final stage: apply pan, clamp into the leftover span and assemble the result.
  logic         f_fsel, f_axis, f_bad, f_neg;
  logic [D-1:0] f_sw, f_sh, f_csz, f_left, f_base, f_dl, f_dt, f_dw, f_dh;
  logic signed [D+1:0] off, pos;
  logic [D-1:0] pos_c, cl_d, ct_d, cw_d, ch_d;

  assign {f_fsel, f_axis, f_bad, f_neg, f_sw, f_sh, f_csz, f_left, f_base,
          f_dl, f_dt, f_dw, f_dh} = side3_q;

  always_comb begin
    off = $signed({2'b00, q3_q});
    if (f_neg) begin
      off = -off;
    end
    pos = $signed({2'b00, f_base}) + off;
    if (pos < 0) begin
      pos_c = '0;
    end else if (pos > $signed({2'b00, f_left})) begin
      pos_c = f_left;
    end else begin
      pos_c = pos[D-1:0];
    end
    pos_c = {pos_c[D-1:1], 1'b0};
    cl_d  = '0;
    ct_d  = '0;
    cw_d  = f_sw;
    ch_d  = f_sh;
    if (f_fsel) begin
      if (f_axis) begin
        ct_d = pos_c;
        ch_d = f_csz;
      end else begin
        cl_d = pos_c;
        cw_d = f_csz;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crop_left_o   <= cl_d;
      crop_top_o    <= ct_d;
      crop_width_o  <= cw_d;
      crop_height_o <= ch_d;
      dest_left_o   <= f_dl;
      dest_top_o    <= f_dt;
      dest_width_o  <= f_dw;
      dest_height_o <= f_dh;
      bad_size_o    <= f_bad;
    end
  end

  assign out_valid_o = out_valid_q;

  // A zero source size always leaves an empty destination.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_size_o |-> dest_width_o == '0 && dest_height_o == '0)
    else $error("bad size result with nonempty destination");

  // Crop origins are always even.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !crop_left_o[0] && !crop_top_o[0])
    else $error("odd crop origin");

  // An accepted transaction enters the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v0_q)
    else $error("accepted transaction lost at entry");

  // A held result stalls the whole pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(v0_q) && $stable(v2_q))
    else $error("pipeline moved during output stall");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the aspect fit or fill crop block.
// Depends on afoc_pkg and the block's RTL; every result is checked against a local predictor or a typed-in expectation.
module testbench;

  localparam int unsigned DimBits = 12;
  localparam int unsigned NumPhases = 11;
  localparam int unsigned ItemsPerPhase = 165;
  localparam int unsigned Latency = 5 + 2 * DimBits;

  typedef logic [DimBits-1:0] dim_t;

  // One placement result, field for field as the block presents it.
  typedef struct packed {
    dim_t crop_left;
    dim_t crop_top;
    dim_t crop_width;
    dim_t crop_height;
    dim_t dest_left;
    dim_t dest_top;
    dim_t dest_width;
    dim_t dest_height;
    logic bad_size;
  } placement_t;

  // One row of the directed stimulus; the placement is only used when typed in.
  typedef struct {
    int unsigned sw;
    int unsigned sh;
    bit          typed;
    placement_t  want;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = afoc_pkg::REG_PANEL_WIDTH;
  dim_t cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dim_t source_width_i = '0;
  dim_t source_height_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  wire placement_t seen;

  // Local copy of the configuration registers.
  int unsigned panel_w = 640;
  int unsigned panel_h = 480;
  bit fill_on = 1'b0;
  int pan = 0;

  placement_t pending_placements[$];
  int unsigned fails = 0;
  bit calm = 1'b0;
  int unsigned hold_request = 0;

  aspect_fit_or_fill_crop #(.DIM_BITS(DimBits)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .source_width_i(source_width_i), .source_height_i(source_height_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .crop_left_o(seen.crop_left), .crop_top_o(seen.crop_top),
    .crop_width_o(seen.crop_width), .crop_height_o(seen.crop_height),
    .dest_left_o(seen.dest_left), .dest_top_o(seen.dest_top),
    .dest_width_o(seen.dest_width), .dest_height_o(seen.dest_height),
    .bad_size_o(seen.bad_size)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Even, centred origin within the leftover span, moved by pan and clamped.
  function automatic int unsigned centre_pan(int unsigned leftover);
    longint pos;
    pos = longint'((leftover / 2) & ~32'd1);
    pos += (longint'(leftover) * pan) / 200;
    if (pos < 0) pos = 0;
    if (pos > leftover) pos = leftover;
    return int'(pos) & ~32'd1;
  endfunction

  // Works out the crop and panel rectangles for one source size.
  function automatic placement_t place_on_panel(int unsigned sw, int unsigned sh);
    placement_t p;
    longint unsigned fw, fh, want;
    int unsigned cl, ct, cw, ch, dl, dt, dw, dh;
    bit bad;
    cl = 0; ct = 0; cw = sw; ch = sh; bad = 1'b0;
    if (fill_on && sw > 0 && sh > 0 && panel_h > 0) begin
      want = longint'(sh) * panel_w / panel_h;
      if (want <= sw) begin
        cw = int'(want) & ~32'd1;
        cl = centre_pan(sw - cw);
      end else begin
        want = longint'(sw) * panel_h / panel_w;
        ch = int'(want) & ~32'd1;
        ct = centre_pan(sh - ch);
      end
      dl = 0; dt = 0; dw = panel_w; dh = panel_h;
    end else if (sw == 0 || sh == 0) begin
      dw = 0; dh = 0; dl = panel_w / 2; dt = panel_h / 2; bad = 1'b1;
    end else begin
      fw = panel_w;
      fh = longint'(panel_w) * sh / sw;
      if (fh > panel_h) begin
        fh = panel_h;
        fw = longint'(panel_h) * sw / sh;
      end
      dw = int'(fw) & ~32'd1;
      dh = int'(fh) & ~32'd1;
      dl = (panel_w - dw) / 2;
      dt = (panel_h - dh) / 2;
    end
    p = '{dim_t'(cl), dim_t'(ct), dim_t'(cw), dim_t'(ch),
          dim_t'(dl), dim_t'(dt), dim_t'(dw), dim_t'(dh), bad};
    return p;
  endfunction

  // Prints one mismatch and counts it.
  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fails++;
  endtask

  // Compares an accepted result with the oldest expected placement.
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_placements.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = pending_placements.pop_front();
        if (seen.crop_left !== want.crop_left) report("crop_left", seen.crop_left, want.crop_left);
        if (seen.crop_top !== want.crop_top) report("crop_top", seen.crop_top, want.crop_top);
        if (seen.crop_width !== want.crop_width)
          report("crop_width", seen.crop_width, want.crop_width);
        if (seen.crop_height !== want.crop_height)
          report("crop_height", seen.crop_height, want.crop_height);
        if (seen.dest_left !== want.dest_left) report("dest_left", seen.dest_left, want.dest_left);
        if (seen.dest_top !== want.dest_top) report("dest_top", seen.dest_top, want.dest_top);
        if (seen.dest_width !== want.dest_width)
          report("dest_width", seen.dest_width, want.dest_width);
        if (seen.dest_height !== want.dest_height)
          report("dest_height", seen.dest_height, want.dest_height);
        if (seen.bad_size !== want.bad_size) report("bad_size", seen.bad_size, want.bad_size);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when the sender asks for one.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  // Offers one transaction and waits until it is accepted.
  task automatic send_size(int unsigned sw, int unsigned sh, bit typed, placement_t want);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    source_width_i <= dim_t'(sw);
    source_height_i <= dim_t'(sh);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_placements.push_back(typed ? want : place_on_panel(sw, sh));
  endtask

  // Writes one configuration register.
  task automatic write_reg(afoc_pkg::reg_idx_e idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= dim_t'(value);
    @(posedge clk_i);
    case (idx)
      afoc_pkg::REG_PANEL_WIDTH: panel_w = value & 12'hFFF;
      afoc_pkg::REG_PANEL_HEIGHT: panel_h = value & 12'hFFF;
      afoc_pkg::REG_FILL_MODE: fill_on = value[0];
      default: pan = int'($signed(value[7:0]));
    endcase
  endtask

  // Lets the pipeline empty before anything that needs the block idle.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  // Random source size, biased towards the corners and towards the panel's aspect.
  task automatic random_size(output int unsigned sw, output int unsigned sh);
    int unsigned pick;
    pick = $urandom_range(99);
    sw = $urandom_range(4095);
    sh = $urandom_range(4095);
    if (pick < 5) begin
      if ($urandom_range(1)) sw = 0; else sh = 0;
      if ($urandom_range(3) == 0) begin sw = 0; sh = 0; end
    end else if (pick < 20) begin
      sw = $urandom_range(64, 1);
      sh = $urandom_range(64, 1);
    end else if (pick < 30) begin
      sw = 4095 - $urandom_range(15);
      sh = $urandom_range(1) ? 4095 - $urandom_range(15) : sh;
    end else if (pick < 50 && panel_w != 0) begin
      sw = $urandom_range(4095, 1);
      sh = (longint'(sw) * panel_h / panel_w + $urandom_range(4)) & 12'hFFF;
    end
  endtask

  initial begin
    directed_row_t rows[$];
    int unsigned phase_w[NumPhases] = '{640, 1920, 4095, 1, 0, 640, 0, 4095, 1280, 720, 800};
    int unsigned phase_h[NumPhases] = '{480, 1080, 4095, 4095, 480, 0, 0, 1, 720, 1280, 600};
    bit phase_fill[NumPhases] = '{0, 1, 1, 1, 1, 1, 0, 0, 1, 0, 1};
    int phase_pan[NumPhases] = '{0, 0, 127, -128, 100, -100, 0, 55, -37, 0, 64};
    int unsigned sw, sh;
    placement_t none;

    none = '0;
    // Directed rows under the reset configuration: corners, zero sizes and common aspect ratios.
    rows.push_back('{0, 0, 1, '{0, 0, 0, 0, 320, 240, 0, 0, 1}});
    rows.push_back('{0, 100, 1, '{0, 0, 0, 100, 320, 240, 0, 0, 1}});
    rows.push_back('{100, 0, 1, '{0, 0, 100, 0, 320, 240, 0, 0, 1}});
    rows.push_back('{640, 480, 1, '{0, 0, 640, 480, 0, 0, 640, 480, 0}});
    rows.push_back('{4095, 4095, 1, '{0, 0, 4095, 4095, 80, 0, 480, 480, 0}});
    rows.push_back('{1, 4095, 1, '{0, 0, 1, 4095, 320, 0, 0, 480, 0}});
    rows.push_back('{4095, 1, 1, '{0, 0, 4095, 1, 0, 240, 640, 0, 0}});
    rows.push_back('{1, 1, 0, none});
    rows.push_back('{1920, 1080, 0, none});
    rows.push_back('{1080, 1920, 0, none});
    rows.push_back('{2730, 1365, 0, none});
    rows.push_back('{641, 479, 0, none});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_size(rows[i].sw, rows[i].sh, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_reg(afoc_pkg::REG_PANEL_WIDTH, phase_w[ph]);
      write_reg(afoc_pkg::REG_PANEL_HEIGHT, phase_h[ph]);
      write_reg(afoc_pkg::REG_FILL_MODE, phase_fill[ph]);
      write_reg(afoc_pkg::REG_PAN_PERCENT, phase_pan[ph] & 8'hFF);
      cfg_we_i <= 1'b0;
      calm = (ph == 8);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Stall the sink for a long stretch so the pipeline fills and backs up.
        if (ph == 2 && n == 10) hold_request = 300;
        // Pause the source until every expected result is out.
        if (ph == 4 && n == 80) drain();
        random_size(sw, sh);
        send_size(sw, sh, 1'b0, none);
      end
    end
    calm = 1'b0;

    drain();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/afoc_pkg.sv
rtl/afoc_cell.sv
rtl/afoc_div_chain.sv
rtl/aspect_fit_or_fill_crop.sv
sim/testbench.sv
